>>> design/gfd_pkg.sv
`timescale 1ns / 1ps

package gfd_pkg;

   // Grid geometry. Row stride is MaxCols; both are powers of two so the
   // word address is {row, col}.
   localparam int MaxCols     = 64;
   localparam int MaxRows     = 64;
   localparam int PosBits     = 6;
   localparam int AddrBits    = 2 * PosBits;
   localparam int GridWords   = MaxCols * MaxRows;
   localparam int CfgSizeBits = 7;

   // Datapath widths
   localparam int DataBits  = 32;
   localparam int AccBits   = DataBits + 3;
   localparam int MagBits   = AccBits - 1;
   localparam int HalfBits  = DataBits / 2;
   localparam int ProdBits  = MagBits + HalfBits;
   localparam int LoBits    = ProdBits + 1 - HalfBits;
   localparam int StepBits  = 4;

   // Configuration register indexes
   localparam int CsrIndexBits = 3;
   localparam logic [CsrIndexBits-1:0] REG_GRID_WIDTH     = 3'd0;
   localparam logic [CsrIndexBits-1:0] REG_GRID_HEIGHT    = 3'd1;
   localparam logic [CsrIndexBits-1:0] REG_INV_DX         = 3'd2;
   localparam logic [CsrIndexBits-1:0] REG_INV_DY         = 3'd3;
   localparam logic [CsrIndexBits-1:0] REG_INV_DX_SQUARED = 3'd4;
   localparam logic [CsrIndexBits-1:0] REG_INV_DY_SQUARED = 3'd5;
   localparam logic [CsrIndexBits-1:0] REG_INV_FOUR_DXDY  = 3'd6;

   // Commands
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WAIT, ST_HOLD} state_type;

   typedef enum logic [1:0] {CLS_LO, CLS_HI, CLS_NEAR, CLS_INNER} axis_class_type;

   typedef enum logic [2:0] {OFS_U1, OFS_V1, OFS_O0, OFS_O1, OFS_O2} tap_sel_type;

   typedef enum logic [1:0] {COEF_PLUS_ONE, COEF_MINUS_ONE, COEF_MINUS_TWO} coef_type;

   typedef enum logic [2:0] {SLOT_DX, SLOT_DXX, SLOT_DY, SLOT_DYY, SLOT_DXY} slot_type;

   typedef enum logic [1:0] {SHIFT_16, SHIFT_17, SHIFT_18} shift_type;

   typedef struct packed {
      coef_type  coef;
      logic      first;
      logic      last;
      slot_type  slot;
      shift_type shift;
   } tap_tag_type;

   typedef struct packed {
      logic        valid;
      tap_tag_type tag;
   } issue_type;

   typedef struct packed {
      logic                wr_en;
      logic [AddrBits-1:0] wr_addr;
      logic [DataBits-1:0] wr_data;
      logic                rd_en;
      logic [AddrBits-1:0] rd_addr;
   } ram_req_type;

   typedef struct packed {
      logic [CfgSizeBits-1:0] width;
      logic [CfgSizeBits-1:0] height;
   } geom_type;

   typedef struct packed {
      logic [DataBits-1:0] inv_dx;
      logic [DataBits-1:0] inv_dy;
      logic [DataBits-1:0] inv_dx_squared;
      logic [DataBits-1:0] inv_dy_squared;
      logic [DataBits-1:0] inv_four_dxdy;
   } coef_set_type;

   typedef struct packed {
      logic [DataBits-1:0] d_x;
      logic [DataBits-1:0] d_y;
      logic [DataBits-1:0] d_xx;
      logic [DataBits-1:0] d_yy;
      logic [DataBits-1:0] d_xy;
      logic                saturated;
   } result_type;

   typedef struct packed {
      logic               rsp_load;
      logic [PosBits-1:0] col;
      logic [PosBits-1:0] row;
   } seq_status_type;

endpackage

>>> design/gfd_channels.sv
`timescale 1ns / 1ps

interface gfd_req_if;
   import gfd_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       command;
   logic signed [DataBits-1:0] sample;
   logic [PosBits-1:0]         col;
   logic [PosBits-1:0]         row;

   modport source (output valid, command, sample, col, row, input ready);
   modport sink (input valid, command, sample, col, row, output ready);
endinterface

interface gfd_rsp_if;
   import gfd_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [PosBits-1:0]         out_col;
   logic [PosBits-1:0]         out_row;
   logic signed [DataBits-1:0] d_x;
   logic signed [DataBits-1:0] d_y;
   logic signed [DataBits-1:0] d_xx;
   logic signed [DataBits-1:0] d_yy;
   logic signed [DataBits-1:0] d_xy;
   logic                       saturated;

   modport source (output valid, out_col, out_row, d_x, d_y, d_xx, d_yy, d_xy, saturated,
                   input ready);
   modport sink (input valid, out_col, out_row, d_x, d_y, d_xx, d_yy, d_xy, saturated,
                 output ready);
endinterface

>>> design/gfd_grid_ram.sv
`timescale 1ns / 1ps

module gfd_grid_ram (
   input  logic                          clock,
   input  gfd_pkg::ram_req_type          ram_req,
   output logic [gfd_pkg::DataBits-1:0]  rd_data
);
   import gfd_pkg::*;

   logic [DataBits-1:0] mem_ff [GridWords];
   logic [DataBits-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem_ff[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rd_data_ff <= mem_ff[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/gfd_scale_unit.sv
`timescale 1ns / 1ps

// Tap accumulator followed by the shared scale pipe:
// numerator -> |num| * k_lo + half -> |num| * k_hi + lo -> shift, round, saturate.
module gfd_scale_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  gfd_pkg::issue_type            issue,
   input  logic [gfd_pkg::DataBits-1:0]  rd_data,
   input  gfd_pkg::coef_set_type         coefs,
   output gfd_pkg::result_type           result,
   output logic                          done
);
   import gfd_pkg::*;

   localparam logic [ProdBits:0] PosLimit = (ProdBits+1)'(64'h7FFF_FFFF);
   localparam logic [ProdBits:0] NegLimit = (ProdBits+1)'(64'h8000_0000);

   // tap stage, aligned with the RAM read data
   logic        tap_valid_ff, tap_valid_in;
   tap_tag_type tag_ff, tag_in;

   // accumulate stage
   logic signed [AccBits-1:0] acc_ff, acc_in;
   logic                      num_valid_ff, num_valid_in;
   logic signed [AccBits-1:0] num_ff, num_in;
   slot_type                  num_slot_ff, num_slot_in;
   shift_type                 num_shift_ff, num_shift_in;

   // low partial product stage
   logic                mul_valid_ff, mul_valid_in;
   logic [MagBits-1:0]  mag_ff, mag_in;
   logic [HalfBits-1:0] kh_ff, kh_in;
   logic [LoBits-1:0]   lo_ff, lo_in;
   logic                neg_ff, neg_in;
   slot_type            mul_slot_ff, mul_slot_in;
   shift_type           mul_shift_ff, mul_shift_in;

   // result slots
   result_type res_ff, res_in;
   logic       done_ff, done_in;

   logic signed [AccBits-1:0] sample_ext;
   logic signed [AccBits-1:0] term;
   logic signed [AccBits-1:0] sum;
   logic signed [AccBits-1:0] abs_val;
   logic [DataBits-1:0]       k_sel;
   logic [ProdBits:0]         half_val;
   logic [ProdBits-1:0]       prod_lo;
   logic [ProdBits:0]         lo_sum;
   logic [ProdBits-1:0]       prod_hi;
   logic [ProdBits:0]         total;
   logic [ProdBits:0]         shifted;
   logic                      clip;
   logic [DataBits-1:0]       value;

   // accumulate
   always_comb begin
      sample_ext = {{(AccBits-DataBits){rd_data[DataBits-1]}}, rd_data};
      case (tag_ff.coef)
         COEF_PLUS_ONE:  term = sample_ext;
         COEF_MINUS_ONE: term = -sample_ext;
         COEF_MINUS_TWO: term = -(sample_ext <<< 1);
         default:        term = '0;
      endcase
      sum = (tag_ff.first ? '0 : acc_ff) + term;

      tap_valid_in = issue.valid;
      tag_in       = issue.tag;
      acc_in       = tap_valid_ff ? sum : acc_ff;
      num_valid_in = tap_valid_ff && tag_ff.last;
      num_in       = sum;
      num_slot_in  = tag_ff.slot;
      num_shift_in = tag_ff.shift;
   end

   // magnitude times low half of the coefficient, rounding constant folded in
   always_comb begin
      abs_val = num_ff[AccBits-1] ? -num_ff : num_ff;
      case (num_slot_ff)
         SLOT_DX:  k_sel = coefs.inv_dx;
         SLOT_DXX: k_sel = coefs.inv_dx_squared;
         SLOT_DY:  k_sel = coefs.inv_dy;
         SLOT_DYY: k_sel = coefs.inv_dy_squared;
         SLOT_DXY: k_sel = coefs.inv_four_dxdy;
         default:  k_sel = '0;
      endcase
      case (num_shift_ff)
         SHIFT_17: half_val = (ProdBits+1)'(1) << (HalfBits);
         SHIFT_18: half_val = (ProdBits+1)'(1) << (HalfBits + 1);
         default:  half_val = (ProdBits+1)'(1) << (HalfBits - 1);
      endcase
      prod_lo = abs_val[MagBits-1:0] * k_sel[HalfBits-1:0];
      lo_sum  = {1'b0, prod_lo} + half_val;

      mul_valid_in = num_valid_ff;
      mag_in       = abs_val[MagBits-1:0];
      kh_in        = k_sel[DataBits-1:HalfBits];
      lo_in        = lo_sum[ProdBits:HalfBits];
      neg_in       = num_ff[AccBits-1];
      mul_slot_in  = num_slot_ff;
      mul_shift_in = num_shift_ff;
   end

   // high half, final shift, saturation
   always_comb begin
      prod_hi = mag_ff * kh_ff;
      total   = {1'b0, prod_hi} + (ProdBits+1)'(lo_ff);
      case (mul_shift_ff)
         SHIFT_17: shifted = total >> 1;
         SHIFT_18: shifted = total >> 2;
         default:  shifted = total;
      endcase
      clip = neg_ff ? (shifted > NegLimit) : (shifted > PosLimit);
      if (clip) begin
         value = neg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         value = neg_ff ? -shifted[DataBits-1:0] : shifted[DataBits-1:0];
      end

      res_in = res_ff;
      if (mul_valid_ff) begin
         case (mul_slot_ff)
            SLOT_DX:  res_in.d_x  = value;
            SLOT_DXX: res_in.d_xx = value;
            SLOT_DY:  res_in.d_y  = value;
            SLOT_DYY: res_in.d_yy = value;
            SLOT_DXY: res_in.d_xy = value;
            default:  ;
         endcase
         // d_x is always the first value of a query
         res_in.saturated = (mul_slot_ff == SLOT_DX) ? clip : (res_ff.saturated | clip);
      end
      done_in = mul_valid_ff && (mul_slot_ff == SLOT_DXY);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_valid_ff <= 1'b0;
         num_valid_ff <= 1'b0;
         mul_valid_ff <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         tap_valid_ff <= tap_valid_in;
         num_valid_ff <= num_valid_in;
         mul_valid_ff <= mul_valid_in;
         done_ff      <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff       <= tag_in;
      acc_ff       <= acc_in;
      num_ff       <= num_in;
      num_slot_ff  <= num_slot_in;
      num_shift_ff <= num_shift_in;
      mag_ff       <= mag_in;
      kh_ff        <= kh_in;
      lo_ff        <= lo_in;
      neg_ff       <= neg_in;
      mul_slot_ff  <= mul_slot_in;
      mul_shift_ff <= mul_shift_in;
      res_ff       <= res_in;
   end

   assign result = res_ff;
   assign done   = done_ff;

endmodule

>>> design/gfd_sequencer.sv
`timescale 1ns / 1ps

// Takes words from the request channel, writes loads into the grid RAM and
// walks the 14 stencil taps of a query, one RAM read per cycle.
module gfd_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   gfd_req_if.sink                 req,
   input  gfd_pkg::geom_type       geom,
   input  logic                    done,
   input  logic                    out_free,
   output gfd_pkg::ram_req_type    ram_req,
   output gfd_pkg::issue_type      issue,
   output gfd_pkg::seq_status_type status
);
   import gfd_pkg::*;

   localparam logic [StepBits-1:0] STEP_DX_A  = 4'd0;
   localparam logic [StepBits-1:0] STEP_DX_B  = 4'd1;
   localparam logic [StepBits-1:0] STEP_DXX_A = 4'd2;
   localparam logic [StepBits-1:0] STEP_DXX_B = 4'd3;
   localparam logic [StepBits-1:0] STEP_DXX_C = 4'd4;
   localparam logic [StepBits-1:0] STEP_DY_A  = 4'd5;
   localparam logic [StepBits-1:0] STEP_DY_B  = 4'd6;
   localparam logic [StepBits-1:0] STEP_DYY_A = 4'd7;
   localparam logic [StepBits-1:0] STEP_DYY_B = 4'd8;
   localparam logic [StepBits-1:0] STEP_DYY_C = 4'd9;
   localparam logic [StepBits-1:0] STEP_DXY_A = 4'd10;
   localparam logic [StepBits-1:0] STEP_DXY_B = 4'd11;
   localparam logic [StepBits-1:0] STEP_DXY_C = 4'd12;
   localparam logic [StepBits-1:0] STEP_DXY_D = 4'd13;

   // tap offsets, two's complement
   localparam logic [2:0] OFF_P2 = 3'b010;
   localparam logic [2:0] OFF_P1 = 3'b001;
   localparam logic [2:0] OFF_Z  = 3'b000;
   localparam logic [2:0] OFF_M1 = 3'b111;
   localparam logic [2:0] OFF_M2 = 3'b110;

   state_type            state_ff, state_in;
   logic [StepBits-1:0]  step_ff, step_in;
   logic [PosBits-1:0]   col_ff, col_in;
   logic [PosBits-1:0]   row_ff, row_in;
   axis_class_type       cls_x_ff, cls_x_in;
   axis_class_type       cls_y_ff, cls_y_in;
   logic [PosBits-1:0]   cs_ff, cs_in;
   logic [PosBits-1:0]   rs_ff, rs_in;

   logic               accept;
   logic               in_grid;
   logic               start;
   logic [PosBits-1:0] tap_col;
   logic [PosBits-1:0] tap_row;
   tap_tag_type        tag;

   function automatic axis_class_type classify(input logic [PosBits-1:0] p,
                                               input logic [CfgSizeBits-1:0] e);
      logic [CfgSizeBits-1:0] pe;
      axis_class_type         cls;
      pe = CfgSizeBits'(p);
      if (pe == e - CfgSizeBits'(1)) begin
         cls = CLS_HI;
      end else if (p == '0) begin
         cls = CLS_LO;
      end else if (pe == CfgSizeBits'(1) || pe == e - CfgSizeBits'(2)) begin
         cls = CLS_NEAR;
      end else begin
         cls = CLS_INNER;
      end
      return cls;
   endfunction

   // cross stencil pulls an edge coordinate one step inward
   function automatic logic [PosBits-1:0] inward(input logic [PosBits-1:0] p,
                                                 input axis_class_type cls);
      logic [PosBits-1:0] q;
      case (cls)
         CLS_HI:  q = p - PosBits'(1);
         CLS_LO:  q = PosBits'(1);
         default: q = p;
      endcase
      return q;
   endfunction

   function automatic logic [2:0] tap_offset(input axis_class_type cls,
                                             input tap_sel_type sel);
      logic [2:0] o;
      o = OFF_Z;
      case (sel)
         OFS_U1: o = (cls == CLS_HI) ? OFF_Z : OFF_P1;
         OFS_V1: o = (cls == CLS_LO) ? OFF_Z : OFF_M1;
         OFS_O0: begin
            case (cls)
               CLS_HI:   o = OFF_Z;
               CLS_NEAR: o = OFF_P1;
               default:  o = OFF_P2;
            endcase
         end
         OFS_O1: begin
            case (cls)
               CLS_LO:  o = OFF_P1;
               CLS_HI:  o = OFF_M1;
               default: o = OFF_Z;
            endcase
         end
         OFS_O2: begin
            case (cls)
               CLS_LO:   o = OFF_Z;
               CLS_NEAR: o = OFF_M1;
               default:  o = OFF_M2;
            endcase
         end
         default: o = OFF_Z;
      endcase
      return o;
   endfunction

   function automatic logic [PosBits-1:0] move(input logic [PosBits-1:0] p,
                                                input logic [2:0] o);
      return p + {{(PosBits-3){o[2]}}, o};
   endfunction

   assign accept  = req.valid && req.ready;
   assign in_grid = (CfgSizeBits'(req.col) < geom.width) &&
                    (CfgSizeBits'(req.row) < geom.height);
   assign start   = accept && (req.command == CMD_QUERY) && in_grid;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start) state_in = ST_RUN;
         ST_RUN:  if (step_ff == STEP_DXY_D) state_in = ST_WAIT;
         ST_WAIT: begin
            if (done) state_in = out_free ? ST_IDLE : ST_HOLD;
         end
         ST_HOLD: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // step counter and query context
   always_comb begin
      step_in  = (state_ff == ST_RUN) ? step_ff + StepBits'(1) : '0;
      col_in   = col_ff;
      row_in   = row_ff;
      cls_x_in = cls_x_ff;
      cls_y_in = cls_y_ff;
      cs_in    = cs_ff;
      rs_in    = rs_ff;
      if (state_ff == ST_IDLE) begin
         col_in   = req.col;
         row_in   = req.row;
         cls_x_in = classify(req.col, geom.width);
         cls_y_in = classify(req.row, geom.height);
         cs_in    = inward(req.col, classify(req.col, geom.width));
         rs_in    = inward(req.row, classify(req.row, geom.height));
      end
   end

   // tap address and tag for the current step
   always_comb begin
      tap_col   = col_ff;
      tap_row   = row_ff;
      tag.coef  = COEF_PLUS_ONE;
      tag.first = 1'b0;
      tag.last  = 1'b0;
      tag.slot  = SLOT_DX;
      tag.shift = SHIFT_16;
      unique case (step_ff)
         STEP_DX_A: begin
            tap_col   = move(col_ff, tap_offset(cls_x_ff, OFS_U1));
            tag.first = 1'b1;
         end
         STEP_DX_B: begin
            tap_col   = move(col_ff, tap_offset(cls_x_ff, OFS_V1));
            tag.coef  = COEF_MINUS_ONE;
            tag.last  = 1'b1;
            tag.shift = (cls_x_ff == CLS_LO || cls_x_ff == CLS_HI) ? SHIFT_16 : SHIFT_17;
         end
         STEP_DXX_A: begin
            tap_col   = move(col_ff, tap_offset(cls_x_ff, OFS_O0));
            tag.first = 1'b1;
            tag.slot  = SLOT_DXX;
         end
         STEP_DXX_B: begin
            tap_col  = move(col_ff, tap_offset(cls_x_ff, OFS_O1));
            tag.coef = COEF_MINUS_TWO;
            tag.slot = SLOT_DXX;
         end
         STEP_DXX_C: begin
            tap_col   = move(col_ff, tap_offset(cls_x_ff, OFS_O2));
            tag.last  = 1'b1;
            tag.slot  = SLOT_DXX;
            tag.shift = (cls_x_ff == CLS_INNER) ? SHIFT_18 : SHIFT_16;
         end
         STEP_DY_A: begin
            tap_row   = move(row_ff, tap_offset(cls_y_ff, OFS_U1));
            tag.first = 1'b1;
            tag.slot  = SLOT_DY;
         end
         STEP_DY_B: begin
            tap_row   = move(row_ff, tap_offset(cls_y_ff, OFS_V1));
            tag.coef  = COEF_MINUS_ONE;
            tag.last  = 1'b1;
            tag.slot  = SLOT_DY;
            tag.shift = (cls_y_ff == CLS_LO || cls_y_ff == CLS_HI) ? SHIFT_16 : SHIFT_17;
         end
         STEP_DYY_A: begin
            tap_row   = move(row_ff, tap_offset(cls_y_ff, OFS_O0));
            tag.first = 1'b1;
            tag.slot  = SLOT_DYY;
         end
         STEP_DYY_B: begin
            tap_row  = move(row_ff, tap_offset(cls_y_ff, OFS_O1));
            tag.coef = COEF_MINUS_TWO;
            tag.slot = SLOT_DYY;
         end
         STEP_DYY_C: begin
            tap_row   = move(row_ff, tap_offset(cls_y_ff, OFS_O2));
            tag.last  = 1'b1;
            tag.slot  = SLOT_DYY;
            tag.shift = (cls_y_ff == CLS_INNER) ? SHIFT_18 : SHIFT_16;
         end
         STEP_DXY_A: begin
            tap_col   = move(cs_ff, OFF_P1);
            tap_row   = move(rs_ff, OFF_P1);
            tag.first = 1'b1;
            tag.slot  = SLOT_DXY;
         end
         STEP_DXY_B: begin
            tap_col  = move(cs_ff, OFF_P1);
            tap_row  = move(rs_ff, OFF_M1);
            tag.coef = COEF_MINUS_ONE;
            tag.slot = SLOT_DXY;
         end
         STEP_DXY_C: begin
            tap_col  = move(cs_ff, OFF_M1);
            tap_row  = move(rs_ff, OFF_P1);
            tag.coef = COEF_MINUS_ONE;
            tag.slot = SLOT_DXY;
         end
         STEP_DXY_D: begin
            tap_col  = move(cs_ff, OFF_M1);
            tap_row  = move(rs_ff, OFF_M1);
            tag.last = 1'b1;
            tag.slot = SLOT_DXY;
         end
         default: ;
      endcase
   end

   // outputs
   always_comb begin
      req.ready       = (state_ff == ST_IDLE);
      ram_req.wr_en   = (state_ff == ST_IDLE) && req.valid &&
                        (req.command == CMD_LOAD) && in_grid;
      ram_req.wr_addr = {req.row, req.col};
      ram_req.wr_data = req.sample;
      ram_req.rd_en   = (state_ff == ST_RUN);
      ram_req.rd_addr = {tap_row, tap_col};
      issue.valid     = (state_ff == ST_RUN);
      issue.tag       = tag;
      status.rsp_load = ((state_ff == ST_WAIT) && done && out_free) ||
                        ((state_ff == ST_HOLD) && out_free);
      status.col      = col_ff;
      status.row      = row_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff   <= col_in;
      row_ff   <= row_in;
      cls_x_ff <= cls_x_in;
      cls_y_ff <= cls_y_in;
      cs_ff    <= cs_in;
      rs_ff    <= rs_in;
   end

endmodule

>>> design/grid_finite_difference_derivatives_top.sv
`timescale 1ns / 1ps

// Loads: one word per cycle while no query is in progress, no result; ready stays high.
// Query: the accepted request word starts 14 grid reads through the single RAM read port,
// then accumulate, two multiply stages and a handoff to the output register.
// The next word is taken in the cycle the result appears, so queries do not overlap.
// Synchronous active-high reset: control idles, registers return to their defaults
// (64 x 64 grid, unit spacing). Grid contents are not cleared.
module grid_finite_difference_derivatives_top (
   input  logic                              clock,
   input  logic                              reset,
   gfd_req_if.sink                           req_port,
   gfd_rsp_if.source                         rsp_port,
   input  logic                              csr_write_enable,
   input  logic [gfd_pkg::CsrIndexBits-1:0]  csr_index,
   input  logic [gfd_pkg::DataBits-1:0]      csr_write_data
);
   import gfd_pkg::*;

   logic [CfgSizeBits-1:0] width_ff, width_in;
   logic [CfgSizeBits-1:0] height_ff, height_in;
   coef_set_type           coefs_ff, coefs_in;

   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_res_ff, rsp_res_in;
   logic [PosBits-1:0] rsp_col_ff, rsp_col_in;
   logic [PosBits-1:0] rsp_row_ff, rsp_row_in;

   geom_type       geom;
   ram_req_type    ram_req;
   issue_type      issue;
   seq_status_type status;
   result_type     result;
   logic [DataBits-1:0] rd_data;
   logic           done;
   logic           out_free;

   function automatic logic [CfgSizeBits-1:0] clamp_size(input logic [CfgSizeBits-1:0] v,
                                                         input logic [CfgSizeBits-1:0] maxv);
      logic [CfgSizeBits-1:0] n;
      n = v;
      if (n < CfgSizeBits'(3)) n = CfgSizeBits'(3);
      if (n > maxv) n = maxv;
      return n;
   endfunction

   // register writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      coefs_in  = coefs_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_GRID_WIDTH:     width_in = csr_write_data[CfgSizeBits-1:0];
            REG_GRID_HEIGHT:    height_in = csr_write_data[CfgSizeBits-1:0];
            REG_INV_DX:         coefs_in.inv_dx = csr_write_data;
            REG_INV_DY:         coefs_in.inv_dy = csr_write_data;
            REG_INV_DX_SQUARED: coefs_in.inv_dx_squared = csr_write_data;
            REG_INV_DY_SQUARED: coefs_in.inv_dy_squared = csr_write_data;
            REG_INV_FOUR_DXDY:  coefs_in.inv_four_dxdy = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff                <= CfgSizeBits'(MaxCols);
         height_ff               <= CfgSizeBits'(MaxRows);
         coefs_ff.inv_dx         <= 32'd65536;
         coefs_ff.inv_dy         <= 32'd65536;
         coefs_ff.inv_dx_squared <= 32'd65536;
         coefs_ff.inv_dy_squared <= 32'd65536;
         coefs_ff.inv_four_dxdy  <= 32'd16384;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         coefs_ff  <= coefs_in;
      end
   end

   assign geom.width  = clamp_size(width_ff, CfgSizeBits'(MaxCols));
   assign geom.height = clamp_size(height_ff, CfgSizeBits'(MaxRows));

   gfd_sequencer u_sequencer (
      .clock    (clock),
      .reset    (reset),
      .req      (req_port),
      .geom     (geom),
      .done     (done),
      .out_free (out_free),
      .ram_req  (ram_req),
      .issue    (issue),
      .status   (status)
   );

   gfd_grid_ram u_grid_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   gfd_scale_unit u_scale_unit (
      .clock   (clock),
      .reset   (reset),
      .issue   (issue),
      .rd_data (rd_data),
      .coefs   (coefs_ff),
      .result  (result),
      .done    (done)
   );

   // output register
   assign out_free = !rsp_valid_ff || rsp_port.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      rsp_res_in   = rsp_res_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      if (status.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = result;
         rsp_col_in   = status.col;
         rsp_row_in   = status.row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
      rsp_col_ff <= rsp_col_in;
      rsp_row_ff <= rsp_row_in;
   end

   assign rsp_port.valid     = rsp_valid_ff;
   assign rsp_port.out_col   = rsp_col_ff;
   assign rsp_port.out_row   = rsp_row_ff;
   assign rsp_port.d_x       = rsp_res_ff.d_x;
   assign rsp_port.d_y       = rsp_res_ff.d_y;
   assign rsp_port.d_xx      = rsp_res_ff.d_xx;
   assign rsp_port.d_yy      = rsp_res_ff.d_yy;
   assign rsp_port.d_xy      = rsp_res_ff.d_xy;
   assign rsp_port.saturated = rsp_res_ff.saturated;

endmodule

>>> design/gfd_checker.sv
`timescale 1ns / 1ps

module gfd_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_command,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [gfd_pkg::DataBits-1:0] rsp_d_x,
   input logic [gfd_pkg::PosBits-1:0]  rsp_out_col
);
   import gfd_pkg::*;

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_d_x) && $stable(rsp_out_col))
      else $error("result word changed while stalled");

   // a load never makes the block busy
   a_load_keeps_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_command == CMD_LOAD |=> req_ready)
      else $error("ready dropped after a load");

   // busy only starts with an accepted word
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      $fell(req_ready) |-> $past(req_valid))
      else $error("ready fell without an accepted word");

   // a result appears only at the end of a busy period
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result word appeared while idle");

endmodule

bind grid_finite_difference_derivatives_top gfd_checker u_gfd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_port.valid),
   .req_ready   (req_port.ready),
   .req_command (req_port.command),
   .rsp_valid   (rsp_port.valid),
   .rsp_ready   (rsp_port.ready),
   .rsp_d_x     (rsp_port.d_x),
   .rsp_out_col (rsp_port.out_col)
);

>>> sim/grid_finite_difference_derivatives_top_tb.sv
`timescale 1ns / 1ps

module grid_finite_difference_derivatives_top_tb;
   import gfd_pkg::*;

   localparam int CycleLimit   = 1000000;
   localparam int SettleCycles = 32;
   localparam int HoldCycles   = 300;
   localparam int PhaseCount   = 7;
   localparam int OpsPerPhase  = 24;
   localparam int FullFillMax  = 64;
   localparam logic [CsrIndexBits-1:0] RegUnused = 3'd7;

   typedef struct packed {
      logic                command;
      logic [DataBits-1:0] sample;
      logic [PosBits-1:0]  col;
      logic [PosBits-1:0]  row;
   } request_type;

   typedef struct packed {
      logic [PosBits-1:0]         col;
      logic [PosBits-1:0]         row;
      logic signed [DataBits-1:0] d_x;
      logic signed [DataBits-1:0] d_y;
      logic signed [DataBits-1:0] d_xx;
      logic signed [DataBits-1:0] d_yy;
      logic signed [DataBits-1:0] d_xy;
      logic                       saturated;
   } derivatives_type;

   logic clock;
   logic reset = 1'b1;
   logic                    csr_write_enable = 1'b0;
   logic [CsrIndexBits-1:0] csr_index = '0;
   logic [DataBits-1:0]     csr_write_data = '0;

   gfd_req_if req_bus ();
   gfd_rsp_if rsp_bus ();

   grid_finite_difference_derivatives_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_port         (req_bus),
      .rsp_port         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Predictor state: grid contents, register copies
   logic [DataBits-1:0]    grid_words [GridWords];
   bit                     plan_known [GridWords];
   logic [CfgSizeBits-1:0] width_reg  = 7'd64;
   logic [CfgSizeBits-1:0] height_reg = 7'd64;
   logic [DataBits-1:0]    inv_dx_reg  = 32'h0001_0000;
   logic [DataBits-1:0]    inv_dy_reg  = 32'h0001_0000;
   logic [DataBits-1:0]    inv_dxx_reg = 32'h0001_0000;
   logic [DataBits-1:0]    inv_dyy_reg = 32'h0001_0000;
   logic [DataBits-1:0]    inv_dxy_reg = 32'h0000_4000;
   bit                     stencil_clean;

   request_type     stimulus_words [$];
   derivatives_type awaited_derivs [$];
   int req_offers = 0;
   int req_accepts = 0;
   int req_gap = 0;
   int req_burst = 0;
   int rsp_stall = 0;
   int rsp_burst = 0;
   int hold_left = 0;
   int hold_asked = 0;
   int hold_served = 0;
   int failures = 0;
   int cycle_count;

   // Generator view of the current phase
   int gen_w, gen_h;
   bit gen_full;
   int hot_col [$];
   int hot_row [$];

   function automatic int clamp_size(input logic [CfgSizeBits-1:0] v, input int maxv);
      int n;
      n = v;
      if (n < 3) n = 3;
      if (n > maxv) n = maxv;
      return n;
   endfunction

   function automatic longint tap(input bit along_x, input int p, input int q);
      int c, r;
      logic [AddrBits-1:0] idx;
      c = along_x ? p : q;
      r = along_x ? q : p;
      idx = {r[PosBits-1:0], c[PosBits-1:0]};
      if (!plan_known[idx]) stencil_clean = 1'b0;
      return longint'($signed(grid_words[idx]));
   endfunction

   // num * k / 2^s, magnitude rounded half away from zero, then clipped
   function automatic logic [DataBits-1:0] scale_round(input longint num,
         input logic [DataBits-1:0] k, input int s, inout bit sat);
      logic [63:0] m, kh, kl, half, lo, mag;
      bit neg;
      neg = num < 0;
      m = neg ? 64'(-num) : 64'(num);
      kh = k[31:16];
      kl = k[15:0];
      half = 64'd1 << (s - 1);
      lo = (m * kl + half) >> 16;
      mag = (m * kh + lo) >> (s - 16);
      if (!neg && mag > 64'h7FFF_FFFF) begin
         sat = 1'b1;
         return 32'h7FFF_FFFF;
      end
      if (neg && mag > 64'h8000_0000) begin
         sat = 1'b1;
         return 32'h8000_0000;
      end
      return neg ? -mag[31:0] : mag[31:0];
   endfunction

   function automatic void axis_derivs(input bit along_x, input int p, input int q,
         input int e, input logic [DataBits-1:0] k1, input logic [DataBits-1:0] k2,
         output logic [DataBits-1:0] d1, output logic [DataBits-1:0] d2, inout bit sat);
      longint n1, n2;
      int s1, s2;
      s1 = 16;
      s2 = 16;
      if (p == e - 1) begin
         n1 = tap(along_x, p, q) - tap(along_x, p - 1, q);
         n2 = tap(along_x, p, q) - 2 * tap(along_x, p - 1, q) + tap(along_x, p - 2, q);
      end else if (p == 0) begin
         n1 = tap(along_x, 1, q) - tap(along_x, 0, q);
         n2 = tap(along_x, 2, q) - 2 * tap(along_x, 1, q) + tap(along_x, 0, q);
      end else if (p == 1 || p == e - 2) begin
         n1 = tap(along_x, p + 1, q) - tap(along_x, p - 1, q);
         s1 = 17;
         n2 = tap(along_x, p + 1, q) - 2 * tap(along_x, p, q) + tap(along_x, p - 1, q);
      end else begin
         n1 = tap(along_x, p + 1, q) - tap(along_x, p - 1, q);
         s1 = 17;
         n2 = tap(along_x, p + 2, q) - 2 * tap(along_x, p, q) + tap(along_x, p - 2, q);
         s2 = 18;
      end
      d1 = scale_round(n1, k1, s1, sat);
      d2 = scale_round(n2, k2, s2, sat);
   endfunction

   function automatic int step_inward(input int p, input int e);
      if (p == e - 1) return p - 1;
      if (p == 0) return 1;
      return p;
   endfunction

   function automatic derivatives_type derive_at(input int c, input int r);
      derivatives_type res;
      logic [DataBits-1:0] d_one, d_two;
      int w, h, cs, rs;
      longint corners;
      bit sat;
      w = clamp_size(width_reg, MaxCols);
      h = clamp_size(height_reg, MaxRows);
      sat = 1'b0;
      res.col = c[PosBits-1:0];
      res.row = r[PosBits-1:0];
      axis_derivs(1'b1, c, r, w, inv_dx_reg, inv_dxx_reg, d_one, d_two, sat);
      res.d_x = d_one;
      res.d_xx = d_two;
      axis_derivs(1'b0, r, c, h, inv_dy_reg, inv_dyy_reg, d_one, d_two, sat);
      res.d_y = d_one;
      res.d_yy = d_two;
      cs = step_inward(c, w);
      rs = step_inward(r, h);
      corners = tap(1'b1, cs + 1, rs + 1) - tap(1'b1, cs + 1, rs - 1)
              - tap(1'b1, cs - 1, rs + 1) + tap(1'b1, cs - 1, rs - 1);
      res.d_xy = scale_round(corners, inv_dxy_reg, 16, sat);
      res.saturated = sat;
      return res;
   endfunction

   function automatic int next_gap(inout int burst);
      int roll;
      if (burst > 0) begin
         burst--;
         return 0;
      end
      roll = $urandom_range(99);
      if (roll < 4) begin
         burst = $urandom_range(20, 80);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [DataBits-1:0] random_sample();
      case ($urandom_range(9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3, 4: return $urandom;
         default: return $urandom_range(0, 32'h003F_FFFF) - 32'h001F_FFFF;
      endcase
   endfunction

   function automatic logic [DataBits-1:0] pick_coef(input int phase);
      if (phase == 3) return 32'hFFFF_FFFF;
      if (phase == 4) return 32'h0;
      case ($urandom_range(7))
         0: return 32'h0001_0000;
         1: return $urandom;
         2: return 32'hFFFF_FFFF;
         default: return $urandom_range(0, 32'h0008_0000);
      endcase
   endfunction

   function automatic int planned_size(input int phase, input bit along_x);
      case (phase)
         1: return 3;
         2: return 64;
         3: return along_x ? 64 : 3;
         4: return along_x ? 3 : 64;
         5: return along_x ? 0 : 127;
         6: return along_x ? 127 : 2;
         default: return ($urandom_range(4) == 0) ? $urandom_range(3, 64) : $urandom_range(3, 12);
      endcase
   endfunction

   function automatic int pick_axis(input int e);
      case ($urandom_range(9))
         0: return 0;
         1: return 1;
         2: return e - 1;
         3: return e - 2;
         default: return $urandom_range(0, e - 1);
      endcase
   endfunction

   task automatic write_reg(input logic [CsrIndexBits-1:0] idx, input logic [DataBits-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      case (idx)
         REG_GRID_WIDTH:     width_reg = data[CfgSizeBits-1:0];
         REG_GRID_HEIGHT:    height_reg = data[CfgSizeBits-1:0];
         REG_INV_DX:         inv_dx_reg = data;
         REG_INV_DY:         inv_dy_reg = data;
         REG_INV_DX_SQUARED: inv_dxx_reg = data;
         REG_INV_DY_SQUARED: inv_dyy_reg = data;
         REG_INV_FOUR_DXDY:  inv_dxy_reg = data;
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic queue_word(input logic command, input logic [DataBits-1:0] value,
         input int c, input int r);
      request_type word;
      word.command = command;
      word.sample = value;
      word.col = c[PosBits-1:0];
      word.row = r[PosBits-1:0];
      stimulus_words = {stimulus_words, word};
      if (command == CMD_LOAD && c < gen_w && r < gen_h) plan_known[{word.row, word.col}] = 1'b1;
   endtask

   task automatic pick_point(output int c, output int r);
      int idx;
      if (gen_full) begin
         c = pick_axis(gen_w);
         r = pick_axis(gen_h);
      end else begin
         idx = $urandom_range(0, hot_col.size() - 1);
         c = hot_col[idx] + $urandom_range(0, 4) - 2;
         r = hot_row[idx] + $urandom_range(0, 4) - 2;
         if (c < 0) c = 0;
         if (c > gen_w - 1) c = gen_w - 1;
         if (r < 0) r = 0;
         if (r > gen_h - 1) r = gen_h - 1;
      end
   endtask

   // Only points whose whole stencil has been loaded are queried
   task automatic queue_query_somewhere();
      int c, r, tries;
      for (tries = 0; tries < 40; tries++) begin
         pick_point(c, r);
         stencil_clean = 1'b1;
         void'(derive_at(c, r));
         if (stencil_clean) begin
            queue_word(CMD_QUERY, $urandom, c, r);
            return;
         end
      end
   endtask

   task automatic queue_noise();
      int c, r;
      if (gen_w == MaxCols && gen_h == MaxRows) begin
         queue_query_somewhere();
         return;
      end
      if (gen_w < MaxCols && (gen_h == MaxRows || $urandom_range(1) == 1)) begin
         c = $urandom_range(gen_w, MaxCols - 1);
         r = $urandom_range(0, MaxRows - 1);
      end else begin
         c = $urandom_range(0, MaxCols - 1);
         r = $urandom_range(gen_h, MaxRows - 1);
      end
      queue_word($urandom_range(1), random_sample(), c, r);
   endtask

   task automatic load_patch(input int cc, input int rr);
      int dc, dr;
      hot_col = {hot_col, cc};
      hot_row = {hot_row, rr};
      for (dr = -2; dr <= 2; dr++)
         for (dc = -2; dc <= 2; dc++)
            if (cc + dc >= 0 && cc + dc < gen_w && rr + dr >= 0 && rr + dr < gen_h)
               queue_word(CMD_LOAD, random_sample(), cc + dc, rr + dr);
   endtask

   task automatic drain();
      while (stimulus_words.size() != 0 || req_accepts != req_offers
             || awaited_derivs.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s expected %0d got %0d", name, want, got);
         failures++;
      end
   endtask

   // Request driver
   always @(negedge clock) begin
      request_type word;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.command <= CMD_LOAD;
         req_bus.sample <= '0;
         req_bus.col <= '0;
         req_bus.row <= '0;
      end else if (req_accepts == req_offers) begin
         if (req_gap > 0) begin
            req_gap--;
            req_bus.valid <= 1'b0;
         end else if (stimulus_words.size() != 0) begin
            word = stimulus_words.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.command <= word.command;
            req_bus.sample <= word.sample;
            req_bus.col <= word.col;
            req_bus.row <= word.row;
            req_offers++;
            req_gap = next_gap(req_burst);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Result ready; a requested hold keeps it low long enough to back up the input
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (hold_served != hold_asked) begin
         hold_served++;
         hold_left = HoldCycles;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         rsp_stall = next_gap(rsp_burst);
      end
   end

   // Predict on each accepted request word, check each accepted result word
   always @(posedge clock) begin
      derivatives_type want;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_derivs.size() == 0) begin
               $error("unexpected result at col %0d row %0d", rsp_bus.out_col, rsp_bus.out_row);
               failures++;
            end else begin
               want = awaited_derivs.pop_front();
               check_field("out_col", want.col, rsp_bus.out_col);
               check_field("out_row", want.row, rsp_bus.out_row);
               check_field("d_x", $signed(want.d_x), rsp_bus.d_x);
               check_field("d_y", $signed(want.d_y), rsp_bus.d_y);
               check_field("d_xx", $signed(want.d_xx), rsp_bus.d_xx);
               check_field("d_yy", $signed(want.d_yy), rsp_bus.d_yy);
               check_field("d_xy", $signed(want.d_xy), rsp_bus.d_xy);
               check_field("saturated", want.saturated, rsp_bus.saturated);
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            req_accepts++;
            if (req_bus.col < clamp_size(width_reg, MaxCols)
                && req_bus.row < clamp_size(height_reg, MaxRows)) begin
               if (req_bus.command == CMD_LOAD)
                  grid_words[{req_bus.row, req_bus.col}] = req_bus.sample;
               else
                  awaited_derivs = {awaited_derivs, derive_at(req_bus.col, req_bus.row)};
            end
         end
      end
   end

   initial begin : watchdog
      for (cycle_count = 0; cycle_count < CycleLimit; cycle_count++) @(posedge clock);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      int phase, n, c, r, roll;
      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Directed: the columns of the 5 x 3 grid hit every axis class; extremes in row 0 force clipping
      write_reg(REG_GRID_WIDTH, 32'd5);
      write_reg(REG_GRID_HEIGHT, 32'd3);
      gen_w = clamp_size(width_reg, MaxCols);
      gen_h = clamp_size(height_reg, MaxRows);
      for (r = 0; r < 3; r++)
         for (c = 0; c < 5; c++)
            if (r == 0)
               queue_word(CMD_LOAD, c[0] ? 32'h8000_0000 : 32'h7FFF_FFFF, c, r);
            else
               queue_word(CMD_LOAD, random_sample(), c, r);
      queue_word(CMD_LOAD, 32'hFFFF_FFFF, 63, 63);
      queue_word(CMD_LOAD, 32'h0, 5, 1);
      queue_word(CMD_QUERY, 32'h0, 0, 0);
      queue_word(CMD_QUERY, 32'hFFFF_FFFF, 4, 2);
      queue_word(CMD_QUERY, $urandom, 2, 1);
      queue_word(CMD_QUERY, $urandom, 1, 0);
      queue_word(CMD_QUERY, $urandom, 3, 1);
      queue_word(CMD_QUERY, $urandom, 63, 63);
      queue_word(CMD_QUERY, $urandom, 0, 3);

      for (phase = 1; phase <= PhaseCount; phase++) begin
         drain();
         write_reg(RegUnused, $urandom);
         write_reg(REG_GRID_WIDTH, ($urandom & ~32'h7F) | 32'(planned_size(phase, 1'b1)));
         write_reg(REG_GRID_HEIGHT, ($urandom & ~32'h7F) | 32'(planned_size(phase, 1'b0)));
         write_reg(REG_INV_DX, pick_coef(phase));
         write_reg(REG_INV_DY, pick_coef(phase));
         write_reg(REG_INV_DX_SQUARED, pick_coef(phase));
         write_reg(REG_INV_DY_SQUARED, pick_coef(phase));
         write_reg(REG_INV_FOUR_DXDY, pick_coef(phase));
         gen_w = clamp_size(width_reg, MaxCols);
         gen_h = clamp_size(height_reg, MaxRows);
         gen_full = gen_w * gen_h <= FullFillMax;
         hot_col.delete();
         hot_row.delete();
         if (gen_full) begin
            for (r = 0; r < gen_h; r++)
               for (c = 0; c < gen_w; c++)
                  queue_word(CMD_LOAD, random_sample(), c, r);
         end else begin
            load_patch(2, 2);
            load_patch(gen_w - 3, 2);
            load_patch(2, gen_h - 3);
            load_patch(gen_w - 3, gen_h - 3);
            load_patch($urandom_range(2, gen_w - 3), $urandom_range(2, gen_h - 3));
            load_patch($urandom_range(2, gen_w - 3), $urandom_range(2, gen_h - 3));
         end
         // once: grid loaded, then stall results while queries keep coming
         if (phase == 2) begin
            drain();
            hold_asked++;
         end
         for (n = 0; n < OpsPerPhase; n++) begin
            roll = $urandom_range(99);
            if (roll < 65) begin
               queue_query_somewhere();
            end else if (roll < 88) begin
               pick_point(c, r);
               queue_word(CMD_LOAD, random_sample(), c, r);
            end else begin
               queue_noise();
            end
         end
      end
      drain();

      if (failures == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
